FILE: hdl/crz_pkg.sv
// ----------------------------------------------------------------------------
// crz_pkg
// Shared constants and types of the circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package crz_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 4;

  // decision term increments and seed of the outline loop
  localparam int K_DIAG  = 10;
  localparam int K_AXIAL = 6;
  localparam int K_INIT  = 3;

  // input kinds carried in tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } crz_qstat_t;

endpackage

`default_nettype wire

FILE: hdl/circle_rasterizer_top.sv
// ----------------------------------------------------------------------------
// circle_rasterizer_top
// Midpoint circle rasterizer: outline points or filled spans per step.
//
//   channel | direction | handshake           | payload
//   in_     | slave     | in_tvalid/in_tready | tdata fields, tuser = action
//   out_    | master    | out_tvalid/tready   | tdata fields, tlast, tuser
//
// A start or step request is taken while the queue is not full; the front
// iteration is one add/compare chain on registered state. Each step then
// yields 4 (filled) or 8 (outline) results at one per cycle from the back
// expander unless output stalls, so that expander sets sustained output. A
// 4-deep record queue lets input run ahead while output stalls. Synchronous
// active-low reset empties the queue and returns the front to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_rasterizer_top #(
  parameter  int COORD_BITS = crz_pkg::COORD_BITS_DEF,
  localparam int IN_W       = ((3 * COORD_BITS + 32 + 7) / 8) * 8,
  localparam int SW         = COORD_BITS + 2,
  localparam int OUT_W      = ((3 * SW + 32 + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // center_x, center_y, radius, color, filled, zero pad
  input  wire logic [IN_W-1:0]   in_tdata,
  // action
  input  wire logic              in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // span_start_x, span_end_x, row_y, pixel_color, zero pad
  output logic [OUT_W-1:0]       out_tdata,
  output logic                   out_tlast,
  // circle_done
  output logic                   out_tuser
);

  import crz_pkg::*;

  localparam int OW = COORD_BITS + 1;
  localparam int RW = 2 * COORD_BITS + 2 * OW + 34;

  logic [COORD_BITS-1:0]  center_x, center_y;
  logic [COORD_BITS-2:0]  radius;
  logic [31:0]            color, pixel_color;
  logic                   filled, fire, push, pop;
  logic [RW-1:0]          wr_rec, rd_rec;
  crz_qstat_t             qstat;
  logic signed [SW-1:0]   span_start_x, span_end_x, row_y;

  assign center_x = in_tdata[COORD_BITS-1:0];
  assign center_y = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign radius   = in_tdata[3*COORD_BITS-2:2*COORD_BITS];
  assign color    = in_tdata[3*COORD_BITS+30:3*COORD_BITS-1];
  assign filled   = in_tdata[3*COORD_BITS+31];

  assign in_tready = !qstat.full;
  assign fire      = in_tvalid && in_tready;

  crz_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .action   (in_tuser),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .color    (color),
    .filled   (filled),
    .push     (push),
    .rec      (wr_rec)
  );

  crz_queue #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .qstat   (qstat)
  );

  crz_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .qstat        (qstat),
    .rec          (rd_rec),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .span_start_x (span_start_x),
    .span_end_x   (span_end_x),
    .row_y        (row_y),
    .pixel_color  (pixel_color),
    .last_of_step (out_tlast),
    .circle_done  (out_tuser)
  );

  assign out_tdata = OUT_W'({pixel_color, row_y, span_end_x, span_start_x});

endmodule

`default_nettype wire

FILE: hdl/crz_front.sv
// ----------------------------------------------------------------------------
// crz_front
// Holds the circle state, runs one loop iteration per step request while busy
// and pushes a step record (centre, offsets, mode, colour, done) to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crz_front #(
  parameter  int COORD_BITS = crz_pkg::COORD_BITS_DEF,
  localparam int OW         = COORD_BITS + 1,
  localparam int DW         = COORD_BITS + 4,
  localparam int RW         = 2 * COORD_BITS + 2 * OW + 34
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    fire,
  input  wire logic                    action,
  input  wire logic [COORD_BITS-1:0]   center_x,
  input  wire logic [COORD_BITS-1:0]   center_y,
  input  wire logic [COORD_BITS-2:0]   radius,
  input  wire logic [31:0]             color,
  input  wire logic                    filled,
  output logic                         push,
  output logic [RW-1:0]                rec
);

  import crz_pkg::*;

  logic [COORD_BITS-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [OW-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [DW-1:0]   d_r, d_nxt, ac_r, ac_nxt, bc_r, bc_nxt;
  logic [31:0]            col_r, col_nxt;
  logic                   fill_r, fill_nxt, busy_r, busy_nxt, first_r, first_nxt;

  logic signed [OW-1:0]   x_inc, y_dec, y_inc, x_dec, rec_x, rec_y;
  logic signed [DW-1:0]   r_ext, d1, dx, dy;
  logic signed [DW:0]     test;
  logic                   done;

  always_comb begin
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    d_nxt     = d_r;
    ac_nxt    = ac_r;
    bc_nxt    = bc_r;
    col_nxt   = col_r;
    fill_nxt  = fill_r;
    busy_nxt  = busy_r;
    first_nxt = first_r;
    push      = 1'b0;
    done      = 1'b0;
    rec_x     = x_r;
    rec_y     = y_r;

    r_ext = signed'(DW'(radius));
    x_inc = x_r + OW'(1);
    y_dec = y_r - OW'(1);
    y_inc = y_r + OW'(1);
    x_dec = x_r - OW'(1);
    dx    = DW'(x_inc);
    dy    = DW'(y_dec);
    d1    = d_r + bc_r;
    test  = ((DW+1)'(d1) <<< 1) + (DW+1)'(ac_r);

    if (fire && action == ACT_START) begin
      cx_nxt    = center_x;
      cy_nxt    = center_y;
      col_nxt   = color;
      fill_nxt  = filled;
      busy_nxt  = 1'b1;
      bc_nxt    = '0;
      if (filled) begin
        x_nxt     = OW'(r_ext);
        y_nxt     = '0;
        ac_nxt    = DW'(1) - (r_ext <<< 1);
        d_nxt     = '0;
        first_nxt = 1'b0;
      end else begin
        x_nxt     = '0;
        y_nxt     = OW'(r_ext);
        d_nxt     = DW'(K_INIT) - (r_ext <<< 1);
        ac_nxt    = '0;
        first_nxt = 1'b1;
      end
    end else if (fire && busy_r) begin
      push = 1'b1;
      if (fill_r) begin
        y_nxt  = y_inc;
        bc_nxt = bc_r + DW'(2);
        d_nxt  = d1;
        if (!test[DW] && test != '0) begin
          x_nxt  = x_dec;
          d_nxt  = d1 + ac_r;
          ac_nxt = ac_r + DW'(2);
        end
        done = x_nxt < y_nxt;
      end else begin
        if (first_r) begin
          first_nxt = 1'b0;
        end else begin
          x_nxt = x_inc;
          if (!d_r[DW-1] && d_r != '0) begin
            y_nxt = y_dec;
            d_nxt = d_r + ((dx - dy) <<< 2) + DW'(K_DIAG);
          end else begin
            d_nxt = d_r + (dx <<< 2) + DW'(K_AXIAL);
          end
        end
        rec_x = x_nxt;
        rec_y = y_nxt;
        done  = y_nxt < x_nxt;
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign rec = {done, fill_r, col_r, rec_y, rec_x, cy_r, cx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      x_r     <= '0;
      y_r     <= '0;
      d_r     <= '0;
      ac_r    <= '0;
      bc_r    <= '0;
      col_r   <= '0;
      fill_r  <= 1'b0;
      busy_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      d_r     <= d_nxt;
      ac_r    <= ac_nxt;
      bc_r    <= bc_nxt;
      col_r   <= col_nxt;
      fill_r  <= fill_nxt;
      busy_r  <= busy_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/crz_queue.sv
// ----------------------------------------------------------------------------
// crz_queue
// Small first-in first-out queue of step records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module crz_queue #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = crz_pkg::QUEUE_DEPTH,
  localparam int PW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              pop,
  output logic [WIDTH-1:0]       rd_data,
  output crz_pkg::crz_qstat_t    qstat
);

  import crz_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign qstat.full  = (cnt_r == CW'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign rd_data     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/crz_back.sv
// ----------------------------------------------------------------------------
// crz_back
// Expands one step record into four spans or eight points, one result
// request per cycle, with the record held while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module crz_back #(
  parameter  int COORD_BITS = crz_pkg::COORD_BITS_DEF,
  localparam int OW         = COORD_BITS + 1,
  localparam int SW         = COORD_BITS + 2,
  localparam int RW         = 2 * COORD_BITS + 2 * OW + 34
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire crz_pkg::crz_qstat_t  qstat,
  input  wire logic [RW-1:0]        rec,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [SW-1:0]      span_start_x,
  output logic signed [SW-1:0]      span_end_x,
  output logic signed [SW-1:0]      row_y,
  output logic [31:0]               pixel_color,
  output logic                      last_of_step,
  output logic                      circle_done
);

  import crz_pkg::*;

  logic [RW-1:0]          cur_r, cur_nxt;
  logic                   vld_r, vld_nxt;
  logic [2:0]             k_r, k_nxt;

  logic [COORD_BITS-1:0]  cx, cy;
  logic signed [OW-1:0]   x, y;
  logic                   fill;
  logic signed [SW-1:0]   cxs, cys, a, b, col_p, col_m, row_p, row_m;
  logic                   fire;

  assign {circle_done, fill, pixel_color, y, x, cy, cx} = cur_r;

  always_comb begin
    cxs = signed'({2'b00, cx});
    cys = signed'({2'b00, cy});
    if (fill ? k_r[1] : k_r[2]) begin
      a = SW'(y);
      b = SW'(x);
    end else begin
      a = SW'(x);
      b = SW'(y);
    end
    col_p = cxs + a;
    col_m = cxs - a;
    row_p = cys + b;
    row_m = cys - b;
    if (fill) begin
      span_start_x = col_m;
      span_end_x   = col_p;
      row_y        = k_r[0] ? row_m : row_p;
      last_of_step = (k_r == 3'd3);
    end else begin
      span_start_x = k_r[0] ? col_m : col_p;
      span_end_x   = span_start_x;
      row_y        = k_r[1] ? row_m : row_p;
      last_of_step = (k_r == 3'd7);
    end
  end

  assign out_valid = vld_r;
  assign fire      = vld_r && out_ready;
  assign pop       = !qstat.empty && (!vld_r || (fire && last_of_step));

  always_comb begin
    cur_nxt = cur_r;
    vld_nxt = vld_r;
    k_nxt   = k_r;
    if (pop) begin
      cur_nxt = rec;
      vld_nxt = 1'b1;
      k_nxt   = '0;
    end else if (fire) begin
      if (last_of_step) begin
        vld_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= '0;
    end else begin
      vld_r <= vld_nxt;
      k_r   <= k_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: test/circle_rasterizer_top_test.sv
// ----------------------------------------------------------------------------
// circle_rasterizer_top_test
// Self-checking bench for the midpoint circle rasterizer. Start and step
// requests go in on the in_ stream; a built-in predictor traces the same
// outline or disc and queues the expected points and spans, which are
// compared field by field with every result taken from the out_ stream.
// Both sides pause at random, with some bursts at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_rasterizer_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = crz_pkg::COORD_BITS_DEF;
  localparam int SPAN_W  = COORD_W + 2;
  localparam int IN_W    = ((3 * COORD_W + 32 + 7) / 8) * 8;
  localparam int OUT_W   = ((3 * SPAN_W + 32 + 7) / 8) * 8;

  localparam bit FILL_OUTLINE = 1'b0;
  localparam bit FILL_DISC    = 1'b1;

  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_TARGET  = 280;
  localparam int PRINT_CAP      = 60;
  localparam int UNBOUNDED      = 1 << 30;

  typedef struct packed {
    logic [SPAN_W-1:0] start_x;
    logic [SPAN_W-1:0] end_x;
    logic [SPAN_W-1:0] row;
    logic [31:0]       color;
    logic              last;
    logic              done;
  } span_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic             out_tuser;

  span_t pending_spans[$];
  int    mismatch_count = 0;
  int    accepted_count = 0;
  bit    sender_eager   = 1'b0;
  bit    sink_eager     = 1'b0;

  // rasterizer state as traced by the bench
  int          ctr_col, ctr_row;
  int          ofs_x, ofs_y;
  int          err_term, x_delta, y_delta;
  logic [31:0] ink;
  bit          fill_on;
  bit          drawing;
  bit          first_octet;

  circle_rasterizer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic span_t make_span(int sx, int ex, int row);
    span_t s;
    s.start_x = sx[SPAN_W-1:0];
    s.end_x   = ex[SPAN_W-1:0];
    s.row     = row[SPAN_W-1:0];
    s.color   = ink;
    s.last    = 1'b0;
    s.done    = 1'b0;
    return s;
  endfunction

  function automatic void advance_raster(bit act, logic [COORD_W-1:0] cx,
                                         logic [COORD_W-1:0] cy,
                                         logic [COORD_W-2:0] r,
                                         logic [31:0] col, bit fill);
    span_t batch[8];
    int    n;
    int    x, y, rad;
    bit    finished;
    if (act == crz_pkg::ACT_START) begin
      rad     = r;
      ctr_col = cx;
      ctr_row = cy;
      ink     = col;
      fill_on = fill;
      drawing = 1'b1;
      if (fill) begin
        ofs_x       = rad;
        ofs_y       = 0;
        x_delta     = 1 - 2 * rad;
        y_delta     = 0;
        err_term    = 0;
        first_octet = 1'b0;
      end else begin
        ofs_x       = 0;
        ofs_y       = rad;
        err_term    = crz_pkg::K_INIT - 2 * rad;
        x_delta     = 0;
        y_delta     = 0;
        first_octet = 1'b1;
      end
      return;
    end
    if (!drawing) begin
      return;
    end
    if (fill_on) begin
      x = ofs_x;
      y = ofs_y;
      batch[0] = make_span(ctr_col - x, ctr_col + x, ctr_row + y);
      batch[1] = make_span(ctr_col - x, ctr_col + x, ctr_row - y);
      batch[2] = make_span(ctr_col - y, ctr_col + y, ctr_row + x);
      batch[3] = make_span(ctr_col - y, ctr_col + y, ctr_row - x);
      n = 4;
      ofs_y = y + 1;
      err_term += y_delta;
      y_delta += 2;
      if (2 * err_term + x_delta > 0) begin
        ofs_x = x - 1;
        err_term += x_delta;
        x_delta += 2;
      end
      finished = ofs_x < ofs_y;
    end else begin
      if (first_octet) begin
        first_octet = 1'b0;
      end else begin
        ofs_x++;
        if (err_term > 0) begin
          ofs_y--;
          err_term += 4 * (ofs_x - ofs_y) + crz_pkg::K_DIAG;
        end else begin
          err_term += 4 * ofs_x + crz_pkg::K_AXIAL;
        end
      end
      x = ofs_x;
      y = ofs_y;
      batch[0] = make_span(ctr_col + x, ctr_col + x, ctr_row + y);
      batch[1] = make_span(ctr_col - x, ctr_col - x, ctr_row + y);
      batch[2] = make_span(ctr_col + x, ctr_col + x, ctr_row - y);
      batch[3] = make_span(ctr_col - x, ctr_col - x, ctr_row - y);
      batch[4] = make_span(ctr_col + y, ctr_col + y, ctr_row + x);
      batch[5] = make_span(ctr_col - y, ctr_col - y, ctr_row + x);
      batch[6] = make_span(ctr_col + y, ctr_col + y, ctr_row - x);
      batch[7] = make_span(ctr_col - y, ctr_col - y, ctr_row - x);
      n = 8;
      finished = ofs_y < ofs_x;
    end
    if (finished) begin
      drawing = 1'b0;
    end
    batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) begin
      batch[k].done = finished;
      pending_spans.push_back(batch[k]);
    end
  endfunction

  task automatic send_request(bit act, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              logic [COORD_W-2:0] r, logic [31:0] col, bit fill);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_W'({fill, col, r, cy, cx});
    do @(posedge clk); while (!in_tready);
    accepted_count++;
    advance_raster(act, cx, cy, r, col, fill);
  endtask

  // step payload is ignored by the block; randomize it anyway
  task automatic step_request();
    send_request(crz_pkg::ACT_STEP, COORD_W'($urandom), COORD_W'($urandom),
                 (COORD_W-1)'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_spans.size() > 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic run_circle(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [COORD_W-2:0] r, logic [31:0] col, bit fill,
                            int max_steps, int extra_steps);
    int steps;
    steps = 0;
    send_request(crz_pkg::ACT_START, cx, cy, r, col, fill);
    while (drawing && steps < max_steps) begin
      step_request();
      steps++;
    end
    repeat (extra_steps) step_request();
  endtask

  task automatic test_idle_steps();
    step_request();
    step_request();
  endtask

  task automatic test_outline_corners();
    run_circle('0, '0, '0, 32'h0000_0000, FILL_OUTLINE, UNBOUNDED, 1);
    run_circle('1, '1, 11'd1, 32'hFFFF_FFFF, FILL_OUTLINE, UNBOUNDED, 0);
  endtask

  task automatic test_disc_corners();
    run_circle('1, '0, '0, 32'hFFFF_FFFF, FILL_DISC, UNBOUNDED, 1);
    run_circle('0, '1, 11'd3, 32'h0000_0000, FILL_DISC, UNBOUNDED, 0);
  endtask

  task automatic test_abandon_largest();
    sender_eager = 1'b1;
    sink_eager   = 1'b1;
    run_circle('1, '1, '1, 32'hA5A5_5A5A, FILL_OUTLINE, 3, 0);
    run_circle('0, '0, '1, 32'h5A5A_A5A5, FILL_DISC, 3, 0);
    sender_eager = 1'b0;
    sink_eager   = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_request(crz_pkg::ACT_START, 12'd2048, 12'd2047, 11'd4, $urandom, FILL_OUTLINE);
    step_request();
    step_request();
    drain_results();
    step_request();
    step_request();
  endtask

  task automatic test_random_circles();
    int pick;
    while (accepted_count < RANDOM_TARGET) begin
      pick = $urandom_range(0, 99);
      sender_eager = ($urandom_range(0, 3) == 0);
      sink_eager   = ($urandom_range(0, 3) == 0);
      if (pick < 6) begin
        step_request();
      end else if (pick < 10) begin
        send_request(crz_pkg::ACT_START, COORD_W'($urandom), COORD_W'($urandom),
                     (COORD_W-1)'($urandom), $urandom, 1'($urandom));
      end else if (pick < 20) begin
        run_circle(COORD_W'($urandom), COORD_W'($urandom),
                   (COORD_W-1)'($urandom_range(0, 2047)),
                   $urandom, 1'($urandom), $urandom_range(1, 6), 0);
      end else begin
        run_circle(COORD_W'($urandom), COORD_W'($urandom),
                   (COORD_W-1)'($urandom_range(0, 24)),
                   $urandom, 1'($urandom),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : UNBOUNDED,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        drain_results();
      end
    end
  endtask

  initial begin
    span_t got;
    span_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.start_x = out_tdata[SPAN_W-1:0];
        got.end_x   = out_tdata[2*SPAN_W-1:SPAN_W];
        got.row     = out_tdata[3*SPAN_W-1:2*SPAN_W];
        got.color   = out_tdata[3*SPAN_W+31:3*SPAN_W];
        got.last    = out_tlast;
        got.done    = out_tuser;
        if (pending_spans.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = pending_spans.pop_front();
          if (got.start_x !== want.start_x) begin
            report_mismatch($sformatf("span_start_x %h, want %h", got.start_x, want.start_x));
          end
          if (got.end_x !== want.end_x) begin
            report_mismatch($sformatf("span_end_x %h, want %h", got.end_x, want.end_x));
          end
          if (got.row !== want.row) begin
            report_mismatch($sformatf("row_y %h, want %h", got.row, want.row));
          end
          if (got.color !== want.color) begin
            report_mismatch($sformatf("pixel_color %h, want %h", got.color, want.color));
          end
          if (got.last !== want.last) begin
            report_mismatch($sformatf("last_of_step %b, want %b", got.last, want.last));
          end
          if (got.done !== want.done) begin
            report_mismatch($sformatf("circle_done %b, want %b", got.done, want.done));
          end
        end
      end
    end
  end

  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = sink_eager ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= crz_pkg::ACT_START;
    in_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_steps();
    test_outline_corners();
    test_disc_corners();
    test_abandon_largest();
    test_drain_pause();
    test_random_circles();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_spans.size() > 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_spans.size()));
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
